>>> hw/rtl/dwc_pkg.sv
// Shared types and constants for the depthwise q15 convolution core.
// Holds operation codes, register indexes, field widths and the command struct.
// No dependencies.
package dwc_pkg;

    localparam int OP_W       = 2;
    localparam int ADDR_W     = 13;
    localparam int VALUE_W    = 16;
    localparam int ROW_W      = 5;
    localparam int COL_W      = 5;
    localparam int CHAN_W     = 3;
    localparam int RES_W      = 16;
    localparam int ACC_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 6;

    // Kernel counters are sized for kernels up to 11 by 11.
    localparam int KDIM_W       = 4;
    localparam int TAP_W        = 7;
    localparam int COORD_W      = 10;
    localparam int DRAIN_W      = 2;
    localparam int DRAIN_CYCLES = 4;

    localparam logic [OP_W-1:0] OP_IMG     = 2'd0;
    localparam logic [OP_W-1:0] OP_WT      = 2'd1;
    localparam logic [OP_W-1:0] OP_BIAS    = 2'd2;
    localparam logic [OP_W-1:0] OP_COMPUTE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_X      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_Y      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_X   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_Y   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_SHIFT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_SHIFT  = 3'd7;

    typedef struct packed {
        logic              start;
        logic              load_img;
        logic              load_wt;
        logic              load_bias;
        logic              tap_valid;
        logic              tap_first;
        logic [KDIM_W-1:0] ky;
        logic [KDIM_W-1:0] kx;
        logic [TAP_W-1:0]  tap;
        logic              finish;
    } t_dp_cmd;

endpackage

>>> hw/rtl/dwc_ctrl.sv
// Controller state machine of the depthwise q15 convolution core.
// Sequences loads, kernel taps, pipeline drain and result hand-off.
// Depends on dwc_pkg.
module dwc_ctrl import dwc_pkg::*; #(
    parameter int KERNEL_X = 3,
    parameter int KERNEL_Y = 3
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [OP_W-1:0] i_op,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output t_dp_cmd         o_cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_FINAL = 2'd3;

    localparam logic [KDIM_W-1:0]  KX_LAST    = KDIM_W'(KERNEL_X - 1);
    localparam logic [KDIM_W-1:0]  KY_LAST    = KDIM_W'(KERNEL_Y - 1);
    localparam logic [DRAIN_W-1:0] DRAIN_LAST = DRAIN_W'(DRAIN_CYCLES - 1);

    logic [1:0]         r_state, n_state;
    logic [KDIM_W-1:0]  r_ky, n_ky;
    logic [KDIM_W-1:0]  r_kx, n_kx;
    logic [TAP_W-1:0]   r_tap, n_tap;
    logic [DRAIN_W-1:0] r_drain, n_drain;
    logic               r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        n_ky    = r_ky;
        n_kx    = r_kx;
        n_tap   = r_tap;
        n_drain = r_drain;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_op)
                        OP_IMG:  o_cmd.load_img  = 1'b1;
                        OP_WT:   o_cmd.load_wt   = 1'b1;
                        OP_BIAS: o_cmd.load_bias = 1'b1;
                        OP_COMPUTE: begin
                            o_cmd.start = 1'b1;
                            n_ky        = '0;
                            n_kx        = '0;
                            n_tap       = '0;
                            n_state     = ST_RUN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RUN: begin
                o_cmd.tap_valid = 1'b1;
                o_cmd.tap_first = (r_tap == '0);
                o_cmd.ky        = r_ky;
                o_cmd.kx        = r_kx;
                o_cmd.tap       = r_tap;
                n_tap           = r_tap + 1'b1;
                if (r_kx == KX_LAST) begin
                    n_kx = '0;
                    if (r_ky == KY_LAST) begin
                        n_drain = '0;
                        n_state = ST_DRAIN;
                    end else begin
                        n_ky = r_ky + 1'b1;
                    end
                end else begin
                    n_kx = r_kx + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (r_drain == DRAIN_LAST) begin
                    n_state = ST_FINAL;
                end else begin
                    n_drain = r_drain + 1'b1;
                end
            end
            ST_FINAL: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        n_out_valid = (r_out_valid && !i_out_ready) || o_cmd.finish;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ky        <= '0;
            r_kx        <= '0;
            r_tap       <= '0;
            r_drain     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ky        <= n_ky;
            r_kx        <= n_kx;
            r_tap       <= n_tap;
            r_drain     <= n_drain;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> hw/rtl/dwc_datapath.sv
// Datapath of the depthwise q15 convolution core: configuration registers,
// image, weight and bias stores, the tap pipeline, accumulator and output stage.
// Depends on dwc_pkg.
module dwc_datapath import dwc_pkg::*; #(
    parameter int MAX_WIDTH  = 32,
    parameter int MAX_HEIGHT = 32,
    parameter int CHANNELS   = 8,
    parameter int KERNEL_X   = 3,
    parameter int KERNEL_Y   = 3
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    input  logic [ADDR_W-1:0]            i_addr,
    input  logic signed [VALUE_W-1:0]    i_value,
    input  logic [ROW_W-1:0]             i_out_row,
    input  logic [COL_W-1:0]             i_out_col,
    input  logic [CHAN_W-1:0]            i_chan,
    input  t_dp_cmd                      i_cmd,
    output logic signed [RES_W-1:0]      o_result
);

    localparam int KK        = KERNEL_X * KERNEL_Y;
    localparam int PIX_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int IMG_DEPTH = PIX_DEPTH * CHANNELS;
    localparam int WT_DEPTH  = CHANNELS * KK;
    localparam int PIX_W     = (PIX_DEPTH > 1) ? $clog2(PIX_DEPTH) : 1;
    localparam int IMG_AW    = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
    localparam int WT_AW     = (WT_DEPTH > 1) ? $clog2(WT_DEPTH) : 1;
    localparam int BIAS_AW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic signed [ACC_W-1:0] SAT_MAX = 32'sd32767;
    localparam logic signed [ACC_W-1:0] SAT_MIN = -32'sd32768;

    logic [5:0] r_in_width, r_in_height;
    logic [2:0] r_pad_x, r_pad_y, r_stride_x, r_stride_y;
    logic [3:0] r_bias_shift;
    logic [4:0] r_out_shift;

    logic signed [VALUE_W-1:0] img_mem  [0:IMG_DEPTH-1];
    logic signed [VALUE_W-1:0] wt_mem   [0:WT_DEPTH-1];
    logic signed [VALUE_W-1:0] bias_mem [0:CHANNELS-1];

    logic signed [COORD_W-1:0] r_base_r, r_base_c;
    logic [CHAN_W-1:0]         r_chan;
    logic                      r_zero;
    logic [WT_AW-1:0]          r_wbase;

    logic                      r_s1_valid, r_s1_first, r_s1_in;
    logic [7:0]                r_s1_r, r_s1_c;
    logic [WT_AW-1:0]          r_s1_wa;
    logic                      r_s2_valid, r_s2_in;
    logic [PIX_W-1:0]          r_s2_pix;
    logic [WT_AW-1:0]          r_s2_wa;
    logic                      r_s3_valid, r_s3_in;
    logic signed [VALUE_W-1:0] r_img_q, r_wt_q, r_bias;
    logic                      r_s4_valid;
    logic signed [ACC_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [RES_W-1:0]   r_result;

    logic [5:0]                w_eff, h_eff;
    logic [7:0]                prod_r, prod_c;
    logic signed [COORD_W-1:0] tap_r, tap_c;
    logic                      tap_in;
    logic [15:0]               pix_full;
    logic [23:0]               ia_full;
    logic [IMG_AW-1:0]         img_ra;
    logic signed [ACC_W-1:0]   acc_init, round_c, shifted;
    logic signed [RES_W-1:0]   sat_n;

    assign w_eff = (32'(r_in_width) < 32'(MAX_WIDTH)) ? r_in_width : 6'(MAX_WIDTH);
    assign h_eff = (32'(r_in_height) < 32'(MAX_HEIGHT)) ? r_in_height : 6'(MAX_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_width   <= 6'd32;
            r_in_height  <= 6'd32;
            r_pad_x      <= 3'd0;
            r_pad_y      <= 3'd0;
            r_stride_x   <= 3'd1;
            r_stride_y   <= 3'd1;
            r_bias_shift <= 4'd0;
            r_out_shift  <= 5'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_IN_WIDTH:   r_in_width   <= i_cfg_data[5:0];
                REG_IN_HEIGHT:  r_in_height  <= i_cfg_data[5:0];
                REG_PAD_X:      r_pad_x      <= i_cfg_data[2:0];
                REG_PAD_Y:      r_pad_y      <= i_cfg_data[2:0];
                REG_STRIDE_X:   r_stride_x   <= i_cfg_data[2:0];
                REG_STRIDE_Y:   r_stride_y   <= i_cfg_data[2:0];
                REG_BIAS_SHIFT: r_bias_shift <= i_cfg_data[3:0];
                REG_OUT_SHIFT:  r_out_shift  <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Window origin of the requested output, taken once per item.
    assign prod_r = 8'(r_stride_y) * 8'(i_out_row);
    assign prod_c = 8'(r_stride_x) * 8'(i_out_col);

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_base_r <= $signed(COORD_W'(prod_r)) - $signed(COORD_W'(r_pad_y));
            r_base_c <= $signed(COORD_W'(prod_c)) - $signed(COORD_W'(r_pad_x));
            r_chan   <= i_chan;
            r_zero   <= (32'(i_chan) >= 32'(CHANNELS));
            r_wbase  <= WT_AW'(32'(i_chan) * 32'(KK));
        end
    end

    assign tap_r  = r_base_r + $signed(COORD_W'(i_cmd.ky));
    assign tap_c  = r_base_c + $signed(COORD_W'(i_cmd.kx));
    assign tap_in = !r_zero && (tap_r >= 0) && (tap_c >= 0)
                    && (tap_r < $signed(COORD_W'(h_eff)))
                    && (tap_c < $signed(COORD_W'(w_eff)));

    assign pix_full = 16'(r_s1_r) * 16'(w_eff) + 16'(r_s1_c);
    assign ia_full  = 24'(r_s2_pix) * 24'(CHANNELS) + 24'(r_chan);
    assign img_ra   = IMG_AW'(ia_full);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_img && (32'(i_addr) < 32'(IMG_DEPTH))) begin
            img_mem[IMG_AW'(i_addr)] <= i_value;
        end
        r_img_q <= img_mem[img_ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wt && (32'(i_addr) < 32'(WT_DEPTH))) begin
            wt_mem[WT_AW'(i_addr)] <= i_value;
        end
        r_wt_q <= wt_mem[r_s2_wa];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_bias && (32'(i_addr) < 32'(CHANNELS))) begin
            bias_mem[BIAS_AW'(i_addr)] <= i_value;
        end
        if (i_cmd.tap_valid && i_cmd.tap_first) begin
            r_bias <= bias_mem[BIAS_AW'(r_chan)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_first <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_cmd.tap_valid;
            r_s1_first <= i_cmd.tap_valid && i_cmd.tap_first;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_in  <= tap_in;
        r_s1_r   <= tap_r[7:0];
        r_s1_c   <= tap_c[7:0];
        r_s1_wa  <= r_wbase + WT_AW'(i_cmd.tap);
        r_s2_in  <= r_s1_in;
        r_s2_pix <= PIX_W'(pix_full);
        r_s2_wa  <= r_s1_wa;
        r_s3_in  <= r_s2_in;
        r_prod   <= r_s3_in ? (r_img_q * r_wt_q) : ACC_W'(0);
    end

    assign round_c  = (r_out_shift != 5'd0) ? (32'sd1 <<< (r_out_shift - 5'd1)) : '0;
    assign acc_init = (ACC_W'(r_bias) <<< r_bias_shift) + round_c;

    always_ff @(posedge i_clk) begin
        if (r_s1_first) begin
            r_acc <= acc_init;
        end else if (r_s4_valid) begin
            r_acc <= r_acc + r_prod;
        end
    end

    assign shifted = r_acc >>> r_out_shift;

    always_comb begin
        if (r_zero) begin
            sat_n = '0;
        end else if (shifted > SAT_MAX) begin
            sat_n = RES_W'(SAT_MAX);
        end else if (shifted < SAT_MIN) begin
            sat_n = RES_W'(SAT_MIN);
        end else begin
            sat_n = RES_W'(shifted);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_result <= sat_n;
        end
    end

    assign o_result = r_result;

endmodule

>>> hw/rtl/depthwise_conv2d_q15_core.sv
// Top level of the depthwise q15 convolution core.
// Joins the controller and the datapath. Depends on dwc_pkg, dwc_ctrl, dwc_datapath.
//
//   Channel   Handshake                  Payload
//   input     i_in_valid / o_in_ready    i_op, i_addr, i_value, i_out_row, i_out_col, i_chan
//   output    o_out_valid / i_out_ready  o_result
//   config    i_cfg_we                   i_cfg_idx, i_cfg_data
//
// A load beat leaves the core ready for the next beat. A compute beat steps through the
// KERNEL_X*KERNEL_Y taps one per cycle through the single read port of the image store,
// then drains the tap pipeline and rounds and saturates before the next acceptance. Reset
// is synchronous and active low; the stores keep their data.
// A result waits in the output register; a new compute beat stalls only at its last step.
module depthwise_conv2d_q15_core import dwc_pkg::*; #(
    parameter int MAX_WIDTH  = 32,
    parameter int MAX_HEIGHT = 32,
    parameter int CHANNELS   = 8,
    parameter int KERNEL_X   = 3,
    parameter int KERNEL_Y   = 3
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [OP_W-1:0]           i_op,
    input  logic [ADDR_W-1:0]         i_addr,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic [ROW_W-1:0]          i_out_row,
    input  logic [COL_W-1:0]          i_out_col,
    input  logic [CHAN_W-1:0]         i_chan,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [RES_W-1:0]   o_result
);

    t_dp_cmd cmd;

    dwc_ctrl #(
        .KERNEL_X (KERNEL_X),
        .KERNEL_Y (KERNEL_Y)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_op        (i_op),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    dwc_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .CHANNELS   (CHANNELS),
        .KERNEL_X   (KERNEL_X),
        .KERNEL_Y   (KERNEL_Y)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_addr     (i_addr),
        .i_value    (i_value),
        .i_out_row  (i_out_row),
        .i_out_col  (i_out_col),
        .i_chan     (i_chan),
        .i_cmd      (cmd),
        .o_result   (o_result)
    );

endmodule

>>> hw/rtl/dwc_checker.sv
// Port-level checker for the depthwise q15 convolution core, with its bind.
// Depends on dwc_pkg and binds to depthwise_conv2d_q15_core.
module dwc_checker import dwc_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_ready,
    input logic [OP_W-1:0]           i_op,
    input logic                      o_out_valid,
    input logic                      i_out_ready,
    input logic signed [RES_W-1:0]   o_result
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_result))
        else $error("result beat changed while stalled");

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_op != OP_COMPUTE) && !o_out_valid |=> !o_out_valid)
        else $error("load beat produced a result");

    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_op == OP_COMPUTE) |=> !o_in_ready)
        else $error("input accepted right after a compute beat");

    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result appeared without a compute in progress");

endmodule

bind depthwise_conv2d_q15_core dwc_checker u_checker (.*);

>>> bench/tb.sv
// Self-checking testbench for depthwise_conv2d_q15_core: random loads and compute beats
// under random idling, checked against a scoreboard that predicts every q15 output.
// Depends on dwc_pkg and the core RTL.
`timescale 1ns / 1ps

module tb import dwc_pkg::*; ();

    localparam int MAX_W       = 32;
    localparam int MAX_H       = 32;
    localparam int CHANNELS    = 8;
    localparam int KX          = 3;
    localparam int KY          = 3;
    localparam int IMG_DEPTH   = MAX_W * MAX_H * CHANNELS;
    localparam int WT_DEPTH    = CHANNELS * KX * KY;
    localparam int PHASE_BEATS = 130;
    localparam int QUIET_WAIT  = 32;
    localparam int CYCLE_LIMIT = 1000000;

    typedef logic [CFG_DATA_W-1:0] t_layer [8];

    class dwconv_tracker;
        logic [5:0] width_r, height_r;
        logic [2:0] pad_x_r, pad_y_r, stride_x_r, stride_y_r;
        logic [3:0] bias_sh;
        logic [4:0] out_sh;
        logic signed [15:0] img_mem [IMG_DEPTH];
        logic signed [15:0] wt_mem [WT_DEPTH];
        logic signed [15:0] bias_mem [CHANNELS];
        bit img_set [IMG_DEPTH];
        bit wt_set [WT_DEPTH];
        bit bias_set [CHANNELS];
        logic signed [15:0] pending_pixels [$];
        int errors;

        function new();
            width_r    = 6'd32;
            height_r   = 6'd32;
            pad_x_r    = 3'd0;
            pad_y_r    = 3'd0;
            stride_x_r = 3'd1;
            stride_y_r = 3'd1;
            bias_sh    = 4'd0;
            out_sh     = 5'd0;
            errors     = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_IN_WIDTH:   width_r = data;
                REG_IN_HEIGHT:  height_r = data;
                REG_PAD_X:      pad_x_r = data[2:0];
                REG_PAD_Y:      pad_y_r = data[2:0];
                REG_STRIDE_X:   stride_x_r = data[2:0];
                REG_STRIDE_Y:   stride_y_r = data[2:0];
                REG_BIAS_SHIFT: bias_sh = data[3:0];
                REG_OUT_SHIFT:  out_sh = data[4:0];
                default: ;
            endcase
        endfunction

        // Returns whether a kernel tap lands inside the image, with its store addresses.
        function bit tap_addr(int row, int col, int ch, int ky, int kx,
                              output int ia, output int wa);
            int w, h, r, c;
            w = (width_r > MAX_W) ? MAX_W : int'(width_r);
            h = (height_r > MAX_H) ? MAX_H : int'(height_r);
            r = int'(stride_y_r) * row + ky - int'(pad_y_r);
            c = int'(stride_x_r) * col + kx - int'(pad_x_r);
            ia = 0;
            wa = ch * KX * KY + ky * KX + kx;
            if (r < 0 || c < 0 || r >= h || c >= w) begin
                return 1'b0;
            end
            ia = (r * w + c) * CHANNELS + ch;
            return 1'b1;
        endfunction

        function logic signed [15:0] predict_pixel(int row, int col, int ch);
            logic [31:0] acc;
            logic signed [31:0] sh;
            int ia, wa, prod;
            acc = int'(bias_mem[ch]);
            acc = acc << bias_sh;
            if (out_sh != 0) begin
                acc += 32'd1 << (out_sh - 1);
            end
            for (int ky = 0; ky < KY; ky++) begin
                for (int kx = 0; kx < KX; kx++) begin
                    if (tap_addr(row, col, ch, ky, kx, ia, wa)) begin
                        prod = int'(img_mem[ia]) * int'(wt_mem[wa]);
                        acc += prod;
                    end
                end
            end
            sh = $signed(acc) >>> out_sh;
            if (sh > 32767) begin
                return 16'sh7fff;
            end
            if (sh < -32768) begin
                return 16'sh8000;
            end
            return sh[15:0];
        endfunction

        // Finds a store entry that a compute beat would read before anything wrote it.
        function bit next_missing(int row, int col, int ch,
                                  output logic [OP_W-1:0] op, output int addr);
            int ia, wa;
            op = OP_BIAS;
            addr = ch;
            if (!bias_set[ch]) begin
                return 1'b1;
            end
            for (int ky = 0; ky < KY; ky++) begin
                for (int kx = 0; kx < KX; kx++) begin
                    if (tap_addr(row, col, ch, ky, kx, ia, wa)) begin
                        if (!wt_set[wa]) begin
                            op = OP_WT;
                            addr = wa;
                            return 1'b1;
                        end
                        if (!img_set[ia]) begin
                            op = OP_IMG;
                            addr = ia;
                            return 1'b1;
                        end
                    end
                end
            end
            return 1'b0;
        endfunction

        function void note_input(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
                                 logic signed [VALUE_W-1:0] value, logic [ROW_W-1:0] row,
                                 logic [COL_W-1:0] col, logic [CHAN_W-1:0] chan);
            case (op)
                OP_IMG: begin
                    if (addr < IMG_DEPTH) begin
                        img_mem[addr] = value;
                        img_set[addr] = 1'b1;
                    end
                end
                OP_WT: begin
                    if (addr < WT_DEPTH) begin
                        wt_mem[addr] = value;
                        wt_set[addr] = 1'b1;
                    end
                end
                OP_BIAS: begin
                    if (addr < CHANNELS) begin
                        bias_mem[addr] = value;
                        bias_set[addr] = 1'b1;
                    end
                end
                default: begin
                    pending_pixels.push_back(predict_pixel(int'(row), int'(col), int'(chan)));
                end
            endcase
        endfunction

        function void check_result(logic signed [RES_W-1:0] got);
            logic signed [15:0] want;
            if (pending_pixels.size() == 0) begin
                $display("%0t: result with none outstanding: expected none, got %0d",
                         $time, got);
                errors++;
            end else begin
                want = pending_pixels.pop_front();
                if (got !== want) begin
                    $display("%0t: result mismatch: expected %0d, got %0d", $time, want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_data = '0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic [OP_W-1:0]           i_op = OP_IMG;
    logic [ADDR_W-1:0]         i_addr = '0;
    logic signed [VALUE_W-1:0] i_value = '0;
    logic [ROW_W-1:0]          i_out_row = '0;
    logic [COL_W-1:0]          i_out_col = '0;
    logic [CHAN_W-1:0]         i_chan = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic signed [RES_W-1:0]   o_result;

    dwconv_tracker book = new();
    int beats_sent = 0;
    int hold_request = 0;
    bit calm = 1'b0;

    depthwise_conv2d_q15_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_op       (i_op),
        .i_addr     (i_addr),
        .i_value    (i_value),
        .i_out_row  (i_out_row),
        .i_out_col  (i_out_col),
        .i_chan     (i_chan),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_result   (o_result)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 88) begin
            return $urandom_range(1, 3);
        end
        if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic int rand_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return -32768;
        end
        if (r == 1) begin
            return 32767;
        end
        if (r == 2) begin
            return $urandom_range(0, 8) - 4;
        end
        return $urandom;
    endfunction

    function automatic int edge_value();
        return $urandom_range(0, 1) ? -32768 : 32767;
    endfunction

    function automatic int pick_pos();
        return ($urandom_range(0, 99) < 70) ? $urandom_range(0, 7) : $urandom_range(0, 31);
    endfunction

    task automatic send_beat(input logic [OP_W-1:0] op, input int addr, input int value,
                             input int row, input int col, input int chan);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_addr     <= addr[ADDR_W-1:0];
        i_value    <= value[VALUE_W-1:0];
        i_out_row  <= row[ROW_W-1:0];
        i_out_col  <= col[COL_W-1:0];
        i_chan     <= chan[CHAN_W-1:0];
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        book.note_input(i_op, i_addr, i_value, i_out_row, i_out_col, i_chan);
        beats_sent++;
    endtask

    task automatic compute_point(input int row, input int col, input int ch);
        logic [OP_W-1:0] mop;
        int maddr;
        while (book.next_missing(row, col, ch, mop, maddr)) begin
            send_beat(mop, maddr, rand_value(), $urandom, $urandom, $urandom);
        end
        send_beat(OP_COMPUTE, $urandom, $urandom, row, col, ch);
    endtask

    // Rewrites the bias, weights and samples of one window, optionally at full scale
    // so that the accumulator overflows and the output saturates.
    task automatic fill_window(input int row, input int col, input int ch, input bit harsh);
        int ia, wa;
        send_beat(OP_BIAS, ch, harsh ? edge_value() : rand_value(), $urandom, $urandom,
                  $urandom);
        for (int ky = 0; ky < KY; ky++) begin
            for (int kx = 0; kx < KX; kx++) begin
                if (book.tap_addr(row, col, ch, ky, kx, ia, wa)) begin
                    send_beat(OP_WT, wa, harsh ? edge_value() : rand_value(), $urandom,
                              $urandom, $urandom);
                    send_beat(OP_IMG, ia, harsh ? edge_value() : rand_value(), $urandom,
                              $urandom, $urandom);
                end
            end
        end
    endtask

    task automatic random_mix(input int n);
        int target, r, row, col, ch, len;
        target = beats_sent + n;
        while (beats_sent < target) begin
            r = $urandom_range(0, 99);
            row = pick_pos();
            col = pick_pos();
            ch = $urandom_range(0, CHANNELS - 1);
            if (r < 60) begin
                compute_point(row, col, ch);
            end else if (r < 72) begin
                fill_window(row, col, ch, 1'($urandom_range(0, 1)));
                compute_point(row, col, ch);
            end else if (r < 80) begin
                len = $urandom_range(2, 4);
                for (int i = 0; i < len; i++) begin
                    compute_point(row, (col + i) % 32, ch);
                end
            end else begin
                send_beat(OP_W'($urandom_range(0, 2)),
                          ($urandom_range(0, 1) != 0) ? $urandom_range(0, 8191)
                                                      : $urandom_range(0, 80),
                          rand_value(), $urandom, $urandom, $urandom);
            end
        end
    endtask

    task automatic program_layer(input t_layer vals);
        for (int i = 0; i < 8; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= i[CFG_IDX_W-1:0];
            i_cfg_data <= vals[i];
            @(posedge i_clk);
            book.set_reg(i[CFG_IDX_W-1:0], vals[i]);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (book.pending_pixels.size() != 0) @(posedge i_clk);
        repeat (QUIET_WAIT) @(posedge i_clk);
    endtask

    initial begin : result_side
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                book.check_result(o_result);
            end
            if (hold_request > 0) begin
                stall_left = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 99) < 20) begin
                stall_left = pick_gap();
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        t_layer rnd;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset-like layout first, with stores hit at their first and last entries,
        // writes past the end of the weight and bias stores, and full-scale values.
        program_layer('{6'd32, 6'd32, 6'd0, 6'd0, 6'd1, 6'd1, 6'd0, 6'd0});
        send_beat(OP_IMG, 8191, -32768, 0, 0, 0);
        send_beat(OP_IMG, 0, 32767, 31, 31, 7);
        send_beat(OP_WT, 63, -32768, 0, 0, 0);
        send_beat(OP_WT, 0, 32767, 31, 31, 7);
        send_beat(OP_WT, 71, 1, 0, 0, 0);
        send_beat(OP_WT, 72, 5, 0, 0, 0);
        send_beat(OP_WT, 8191, -1, 31, 31, 7);
        send_beat(OP_BIAS, 7, 32767, 0, 0, 0);
        send_beat(OP_BIAS, 0, -32768, 0, 0, 0);
        send_beat(OP_BIAS, 8, 3, 31, 31, 7);
        send_beat(OP_BIAS, 8191, 0, 0, 0, 0);
        compute_point(31, 31, 7);
        compute_point(31, 31, 0);
        send_beat(OP_COMPUTE, 8191, -1, 31, 31, 7);
        random_mix(100);
        settle();

        program_layer('{6'd4, 6'd4, 6'd1, 6'd1, 6'd1, 6'd1, 6'd3, 6'd8});
        random_mix(70);
        settle();
        hold_request = 400;
        for (int i = 0; i < 8; i++) begin
            compute_point($urandom_range(0, 3), $urandom_range(0, 3),
                          $urandom_range(0, CHANNELS - 1));
        end
        random_mix(60);
        settle();

        // Oversized image, widest padding and stride, largest shifts.
        program_layer('{6'd63, 6'd63, 6'd7, 6'd7, 6'd7, 6'd7, 6'd15, 6'd31});
        random_mix(PHASE_BEATS);
        settle();

        // Zero width leaves only bias and rounding; zero stride reuses one window.
        program_layer('{6'd0, 6'd5, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd1});
        random_mix(PHASE_BEATS);
        settle();

        program_layer('{6'd1, 6'd1, 6'd0, 6'd0, 6'd2, 6'd2, 6'd0, 6'd16});
        random_mix(PHASE_BEATS);
        settle();

        program_layer('{6'd33, 6'd2, 6'd3, 6'd0, 6'd0, 6'd3, 6'd15, 6'd0});
        random_mix(PHASE_BEATS);
        settle();

        calm = 1'b1;
        program_layer('{6'd8, 6'd8, 6'd1, 6'd1, 6'd1, 6'd2, 6'd4, 6'd12});
        random_mix(PHASE_BEATS);
        settle();
        calm = 1'b0;

        for (int p = 0; p < 3; p++) begin
            foreach (rnd[i]) begin
                rnd[i] = CFG_DATA_W'($urandom_range(0, 63));
            end
            program_layer(rnd);
            random_mix(PHASE_BEATS);
            settle();
        end

        if (book.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/dwc_pkg.sv
hw/rtl/dwc_ctrl.sv
hw/rtl/dwc_datapath.sv
hw/rtl/depthwise_conv2d_q15_core.sv
hw/rtl/dwc_checker.sv
bench/tb.sv
